// ===== rtl/nps_pkg.sv =====
// Shared types and constants of the nearest point steering block.
package nps_pkg;

   localparam int NPS_MAX_POINTS = 256;
   localparam int NPS_FRAC_BITS  = 16;
   localparam logic [30:0] NPS_MAG_RESET = 31'((1 << NPS_FRAC_BITS) / 100);

   localparam int NPS_NUM_W  = 65;   // |u| times max_magnitude
   localparam int NPS_DEN_W  = 36;   // integer square root of the squared length
   localparam int NPS_QUO_W  = 31;   // quotient, known to stay below 2^31
   localparam int NPS_SUM_W  = 70;   // sum of three squares
   localparam int NPS_SQ_W   = 68;   // one square

   // Configuration register indexes.
   localparam logic NPS_CSR_MAX_MAG     = 1'b0;
   localparam logic NPS_CSR_POINT_COUNT = 1'b1;

   // Input command codes.
   localparam logic NPS_CMD_LOAD  = 1'b0;
   localparam logic NPS_CMD_QUERY = 1'b1;

   typedef enum logic [3:0] {
      NPS_IDLE,
      NPS_SCAN,
      NPS_UDIFF,
      NPS_UABS,
      NPS_USQ,
      NPS_USUM,
      NPS_UCMP,
      NPS_SQRT,
      NPS_PROD,
      NPS_DIVGO,
      NPS_DIVW,
      NPS_DONE
   } nps_state_type;

   typedef struct packed {
      logic                 start;
      logic [NPS_NUM_W-1:0] num;
      logic [NPS_DEN_W-1:0] den;
   } nps_div_req_type;

   typedef struct packed {
      logic                 done;
      logic [NPS_QUO_W-1:0] quo;
   } nps_div_rsp_type;

endpackage

// ===== rtl/nps_div.sv =====
// Restoring divider, one quotient bit per cycle, for the steering clamp.
module nps_div
   import nps_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  nps_div_req_type req,
   output nps_div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [NPS_DEN_W-1:0] rem_ff, rem_in;
   logic [NPS_DEN_W-1:0] den_ff, den_in;
   logic [NPS_QUO_W-1:0] low_ff, low_in;
   logic [NPS_QUO_W-1:0] quo_ff, quo_in;
   logic [NPS_DEN_W:0]   trial;
   logic                 fits;

   assign trial = {rem_ff, low_ff[NPS_QUO_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         // The quotient stays below 2^31, so the upper numerator bits are below den.
         busy_in = 1'b1;
         cnt_in  = 5'(NPS_QUO_W - 1);
         rem_in  = NPS_DEN_W'(req.num[NPS_NUM_W-1:NPS_QUO_W]);
         low_in  = req.num[NPS_QUO_W-1:0];
         den_in  = req.den;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? NPS_DEN_W'(trial - {1'b0, den_ff}) : trial[NPS_DEN_W-1:0];
         quo_in = {quo_ff[NPS_QUO_W-2:0], fits};
         low_in = {low_ff[NPS_QUO_W-2:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

// ===== rtl/nearest_point_steering_core.sv =====
// Nearest point steering core. A load beat (tuser 0) writes one table point; a query beat
// (tuser 1) scans entries 0 .. n-1 through one synchronous table read per cycle, where n is
// point_count limited to MAX_POINTS, and returns one result beat. The scan reads the table
// through its single read port; a query whose steering vector needs clamping also runs a
// 35-step square root and three 31-step divisions on one shared divider. One query is in
// flight at a time; the result register lets the next beat be taken while a result waits.
module nearest_point_steering_core
   import nps_pkg::*;
#(
   parameter int MAX_POINTS = NPS_MAX_POINTS
) (
   input  logic         clock,
   input  logic         reset,
   // Configuration writes.
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [30:0]  csr_wdata,
   // Request stream.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [199:0] req_tdata,  // point_index, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
   input  logic         req_tuser,  // command
   // Response stream.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,  // steer_x, steer_y, steer_z, nearest_index
   output logic [1:0]   rsp_tuser   // was_clamped, no_target
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);

   nps_state_type state_ff, state_in;

   logic [30:0] mag_ff;
   logic [8:0]  pcount_ff;

   logic [7:0]  in_index;
   logic [31:0] in_pos [3];
   logic [31:0] in_vel [3];
   logic        req_beat;
   logic        rsp_beat;

   logic [95:0] mem [MAX_POINTS];
   logic [95:0] rd_data_ff;

   logic signed [31:0] pos_ff [3];
   logic signed [31:0] vel_ff [3];
   logic [CW-1:0]      n_ff;
   logic [CW-1:0]      addr_ff;

   // Scan pipeline: read, difference, square, sum, compare.
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic [AW-1:0]      i1_ff, i2_ff, i3_ff, i4_ff;
   logic signed [32:0] d2_ff [3];
   logic signed [32:0] d3_ff [3];
   logic signed [32:0] d4_ff [3];
   logic               issue;
   logic               scan_done;

   logic                 have_best_ff;
   logic [AW-1:0]        best_ff;
   logic [NPS_SUM_W-1:0] best_sum_ff;
   logic signed [32:0]   best_d_ff [3];

   logic signed [33:0]     u_ff [3];
   logic [33:0]            umag_ff [3];
   logic [2:0]             uneg_ff;
   logic signed [33:0]     mop [3];
   logic signed [67:0]     mprod [3];
   logic [NPS_SQ_W-1:0]    sq_ff [3];
   logic [NPS_SUM_W-1:0]   sum_ff;
   logic [33:0]            pop;
   logic [NPS_NUM_W-1:0]   prod_ff;

   logic [NPS_SUM_W-1:0] sop_ff, sres_ff, sone_ff;
   logic [NPS_SUM_W-1:0] strial;
   logic [1:0]           k_ff;

   logic [31:0] res_ff [3];
   logic        res_clamp_ff;
   logic        res_none_ff;

   logic        rsp_valid_ff;
   logic [103:0] rsp_data_ff;
   logic [1:0]   rsp_user_ff;

   nps_div_req_type div_req;
   nps_div_rsp_type div_rsp;

   nps_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign in_index  = req_tdata[7:0];
   assign in_pos[0] = req_tdata[39:8];
   assign in_pos[1] = req_tdata[71:40];
   assign in_pos[2] = req_tdata[103:72];
   assign in_vel[0] = req_tdata[135:104];
   assign in_vel[1] = req_tdata[167:136];
   assign in_vel[2] = req_tdata[199:168];

   assign req_tready = (state_ff == NPS_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_beat   = rsp_valid_ff && rsp_tready;

   assign issue     = (state_ff == NPS_SCAN) && (addr_ff < n_ff);
   assign scan_done = (addr_ff == n_ff) && !v1_ff && !v2_ff && !v3_ff && !v4_ff;
   assign strial    = sres_ff + sone_ff;

   assign div_req.start = (state_ff == NPS_DIVGO);
   assign div_req.num   = prod_ff;
   assign div_req.den   = sres_ff[NPS_DEN_W-1:0];

   // The three squarers serve the scan and then the steering vector.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mop[k]   = (state_ff == NPS_SCAN) ? 34'(d2_ff[k]) : u_ff[k];
         mprod[k] = mop[k] * mop[k];
      end
      pop = (state_ff == NPS_USQ) ? 34'(mag_ff) : umag_ff[k_ff];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         NPS_IDLE: begin
            if (req_beat && req_tuser == NPS_CMD_QUERY) begin
               state_in = (pcount_ff == 9'd0) ? NPS_DONE : NPS_SCAN;
            end
         end
         NPS_SCAN:  if (scan_done) state_in = NPS_UDIFF;
         NPS_UDIFF: state_in = NPS_UABS;
         NPS_UABS:  state_in = NPS_USQ;
         NPS_USQ:   state_in = NPS_USUM;
         NPS_USUM:  state_in = NPS_UCMP;
         NPS_UCMP:  state_in = (NPS_SUM_W'(prod_ff) < sum_ff) ? NPS_SQRT : NPS_DONE;
         NPS_SQRT:  if (sone_ff == NPS_SUM_W'(1)) state_in = NPS_PROD;
         NPS_PROD:  state_in = NPS_DIVGO;
         NPS_DIVGO: state_in = NPS_DIVW;
         NPS_DIVW: begin
            if (div_rsp.done) state_in = (k_ff == 2'd2) ? NPS_DONE : NPS_PROD;
         end
         NPS_DONE:  if (!rsp_valid_ff || rsp_tready) state_in = NPS_IDLE;
         default:   state_in = NPS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= NPS_IDLE;
      else       state_ff <= state_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff    <= NPS_MAG_RESET;
         pcount_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            NPS_CSR_MAX_MAG:     mag_ff    <= csr_wdata;
            NPS_CSR_POINT_COUNT: pcount_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // Point table: one write port for loads, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (req_beat && req_tuser == NPS_CMD_LOAD && 32'(in_index) < MAX_POINTS) begin
         mem[AW'(in_index)] <= {in_pos[2], in_pos[1], in_pos[0]};
      end
      if (issue) begin
         rd_data_ff <= mem[addr_ff[AW-1:0]];
      end
   end

   // Scan pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         have_best_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         if (req_beat) begin
            have_best_ff <= 1'b0;
         end else if (v4_ff) begin
            have_best_ff <= 1'b1;
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      if (req_beat) begin
         for (int k = 0; k < 3; k++) begin
            pos_ff[k] <= in_pos[k];
            vel_ff[k] <= in_vel[k];
            res_ff[k] <= '0;
         end
         n_ff         <= (32'(pcount_ff) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(pcount_ff);
         addr_ff      <= '0;
         best_ff      <= '0;
         res_clamp_ff <= 1'b0;
         res_none_ff  <= (pcount_ff == 9'd0);
      end
      if (issue) begin
         addr_ff <= addr_ff + CW'(1);
      end
      i1_ff <= addr_ff[AW-1:0];
      i2_ff <= i1_ff;
      i3_ff <= i2_ff;
      i4_ff <= i3_ff;
      for (int k = 0; k < 3; k++) begin
         d2_ff[k] <= 33'($signed(rd_data_ff[32*k +: 32])) - 33'(pos_ff[k]);
         d3_ff[k] <= d2_ff[k];
         d4_ff[k] <= d3_ff[k];
      end
      if (state_ff == NPS_SCAN || state_ff == NPS_USQ) begin
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= NPS_SQ_W'(unsigned'(mprod[k]));
         end
      end
      if (state_ff == NPS_SCAN || state_ff == NPS_USUM) begin
         sum_ff <= NPS_SUM_W'(sq_ff[0]) + NPS_SUM_W'(sq_ff[1]) + NPS_SUM_W'(sq_ff[2]);
      end
      // The earliest entry wins a tie: only a strictly smaller distance replaces it.
      if (v4_ff && (!have_best_ff || sum_ff < best_sum_ff)) begin
         best_sum_ff <= sum_ff;
         best_ff     <= i4_ff;
         for (int k = 0; k < 3; k++) begin
            best_d_ff[k] <= d4_ff[k];
         end
      end

      case (state_ff)
         NPS_UDIFF: begin
            for (int k = 0; k < 3; k++) begin
               u_ff[k] <= 34'(best_d_ff[k]) - 34'(vel_ff[k]);
            end
         end
         NPS_UABS: begin
            for (int k = 0; k < 3; k++) begin
               uneg_ff[k] <= u_ff[k][33];
               umag_ff[k] <= u_ff[k][33] ? 34'(-u_ff[k]) : 34'(u_ff[k]);
            end
         end
         NPS_USQ, NPS_PROD: begin
            prod_ff <= NPS_NUM_W'(pop) * NPS_NUM_W'(mag_ff);
         end
         NPS_UCMP: begin
            k_ff <= 2'd0;
            if (NPS_SUM_W'(prod_ff) < sum_ff) begin
               res_clamp_ff <= 1'b1;
               sop_ff       <= sum_ff;
               sres_ff      <= '0;
               sone_ff      <= NPS_SUM_W'(1) << (NPS_SUM_W - 2);
            end else begin
               for (int k = 0; k < 3; k++) begin
                  res_ff[k] <= u_ff[k][31:0];
               end
            end
         end
         NPS_SQRT: begin
            // Digit-by-digit square root: one result bit per cycle.
            if (sop_ff >= strial) begin
               sop_ff  <= sop_ff - strial;
               sres_ff <= (sres_ff >> 1) + sone_ff;
            end else begin
               sres_ff <= sres_ff >> 1;
            end
            sone_ff <= sone_ff >> 2;
         end
         NPS_DIVW: begin
            if (div_rsp.done) begin
               res_ff[k_ff] <= uneg_ff[k_ff] ? 32'(-{1'b0, div_rsp.quo})
                                             : 32'({1'b0, div_rsp.quo});
               k_ff <= k_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == NPS_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_beat) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == NPS_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {(res_none_ff ? 8'd0 : 8'(best_ff)), res_ff[2], res_ff[1], res_ff[0]};
         rsp_user_ff <= {res_none_ff, res_clamp_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== sim/nps_checker.sv =====
`timescale 1ns / 1ps
// Checker for the nearest point steering core: predicts each query result and compares beats.
module nps_checker
   import nps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [30:0]  csr_wdata,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [199:0] req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   output int           fail_count,
   output int           pending_count
);

   typedef struct packed {
      logic [31:0] sx;
      logic [31:0] sy;
      logic [31:0] sz;
      logic [7:0]  nearest;
      logic        clamped;
      logic        no_target;
   } steer_result_type;

   logic signed [31:0] pt_x [NPS_MAX_POINTS];
   logic signed [31:0] pt_y [NPS_MAX_POINTS];
   logic signed [31:0] pt_z [NPS_MAX_POINTS];
   logic [30:0]        mag_limit;
   logic [8:0]         search_count;
   steer_result_type   steer_queue [$];

   function automatic logic [69:0] sum_squares(logic signed [35:0] a, logic signed [35:0] b,
                                               logic signed [35:0] c);
      logic [69:0] s;
      s = 70'(a) * 70'(a) + 70'(b) * 70'(b) + 70'(c) * 70'(c);
      return s;
   endfunction

   function automatic logic signed [31:0] clamp_axis(logic signed [35:0] u, logic [35:0] len);
      logic [35:0] ua;
      logic [69:0] q;
      ua = u < 0 ? -u : u;
      q = (70'(ua) * 70'(mag_limit)) / 70'(len);
      return u < 0 ? -32'(q) : 32'(q);
   endfunction

   function automatic steer_result_type predict_steering(logic [199:0] d);
      steer_result_type r;
      logic signed [35:0] px, py, pz, ux, uy, uz;
      logic [69:0] span_sq, best_dist, len_sq;
      logic [35:0] len, cand;
      int n, best;
      px = 36'(signed'(d[39:8]));
      py = 36'(signed'(d[71:40]));
      pz = 36'(signed'(d[103:72]));
      r = '0;
      n = search_count > NPS_MAX_POINTS ? NPS_MAX_POINTS : search_count;
      if (n == 0) begin
         r.no_target = 1'b1;
         return r;
      end
      best = 0;
      best_dist = '0;
      for (int i = 0; i < n; i++) begin
         span_sq = sum_squares(36'(pt_x[i]) - px, 36'(pt_y[i]) - py, 36'(pt_z[i]) - pz);
         if (i == 0 || span_sq < best_dist) begin
            best_dist = span_sq;
            best = i;
         end
      end
      ux = 36'(pt_x[best]) - px - 36'(signed'(d[135:104]));
      uy = 36'(pt_y[best]) - py - 36'(signed'(d[167:136]));
      uz = 36'(pt_z[best]) - pz - 36'(signed'(d[199:168]));
      len_sq = sum_squares(ux, uy, uz);
      if (len_sq > 70'(mag_limit) * 70'(mag_limit)) begin
         len = '0;
         for (int b = 35; b >= 0; b--) begin
            cand = len | (36'd1 << b);
            if (72'(cand) * 72'(cand) <= 72'(len_sq))
               len = cand;
         end
         r.clamped = 1'b1;
         ux = 36'(clamp_axis(ux, len));
         uy = 36'(clamp_axis(uy, len));
         uz = 36'(clamp_axis(uz, len));
      end
      r.sx = ux[31:0];
      r.sy = uy[31:0];
      r.sz = uz[31:0];
      r.nearest = 8'(best);
      return r;
   endfunction

   always @(posedge clock) begin
      steer_result_type want, got;
      if (reset) begin
         mag_limit <= NPS_MAG_RESET;
         search_count <= '0;
         fail_count <= 0;
         pending_count <= 0;
         steer_queue.delete();
      end else begin
         if (csr_we) begin
            if (csr_addr == NPS_CSR_MAX_MAG) mag_limit <= csr_wdata;
            else search_count <= csr_wdata[8:0];
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == NPS_CMD_LOAD) begin
               pt_x[req_tdata[7:0]] = req_tdata[39:8];
               pt_y[req_tdata[7:0]] = req_tdata[71:40];
               pt_z[req_tdata[7:0]] = req_tdata[103:72];
            end else begin
               steer_queue.insert(steer_queue.size(), predict_steering(req_tdata));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.sx        = rsp_tdata[31:0];
            got.sy        = rsp_tdata[63:32];
            got.sz        = rsp_tdata[95:64];
            got.nearest   = rsp_tdata[103:96];
            got.clamped   = rsp_tuser[0];
            got.no_target = rsp_tuser[1];
            if (steer_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected result beat %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = steer_queue.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display({"mismatch: expected x %h y %h z %h idx %0d cl %b nt %b, ",
                               "got x %h y %h z %h idx %0d cl %b nt %b"},
                        want.sx, want.sy, want.sz, want.nearest, want.clamped,
                        want.no_target, got.sx, got.sy, got.sz, got.nearest,
                        got.clamped, got.no_target);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= steer_queue.size();
      end
   end

endmodule

// ===== sim/tb_nearest_point_steering_core.sv =====
`timescale 1ns / 1ps
// Testbench top for the nearest point steering core: stimulus, configuration phases and verdict.
module tb_nearest_point_steering_core;
   import nps_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic         csr_addr = NPS_CSR_MAX_MAG;
   logic [30:0]  csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [199:0] req_tdata = '0;
   logic         req_tuser = NPS_CMD_LOAD;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   int           fail_count;
   int           pending_count;
   int           cycle_count = 0;
   int           loaded_count = 0;  // entries 0 .. loaded_count-1 are written
   logic         stall_free = 1'b0;

   localparam int CYCLE_LIMIT = 1500000;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   nearest_point_steering_core u_top (.*);

   nps_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_nearest_point_steering_core NOT OK");
         $finish;
      end
   end

   function automatic int gap_length();
      if (stall_free) return 0;
      if ($urandom_range(0, 9) < 7) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Receiver side: random backpressure.
   always @(posedge clock) begin
      rsp_tready <= (gap_length() == 0);
   end

   function automatic logic [31:0] coord_value(int kind);
      case (kind)
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'($signed($urandom_range(0, 400000)) - 200000);
         default: return $urandom;
      endcase
   endfunction

   // The beat stays valid after acceptance until the next gap or an idle phase drops it.
   task automatic send_beat(logic cmd, logic [7:0] idx, logic [31:0] px, logic [31:0] py,
                            logic [31:0] pz, logic [31:0] vx, logic [31:0] vy,
                            logic [31:0] vz);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {vz, vy, vx, pz, py, px, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic load_point(logic [7:0] idx, int kind);
      send_beat(NPS_CMD_LOAD, idx, coord_value(kind), coord_value(kind), coord_value(kind),
                $urandom, $urandom, $urandom);
   endtask

   task automatic query(int kind);
      send_beat(NPS_CMD_QUERY, 8'($urandom), coord_value(kind), coord_value(kind),
                coord_value(kind), coord_value(kind), coord_value(kind), coord_value(kind));
   endtask

   task automatic csr_write(logic addr, logic [30:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_count(int limit_hi);
      int c;
      c = $urandom_range(0, 9) == 0 ? limit_hi : $urandom_range(1, 8);
      if (c > loaded_count) c = loaded_count;
      csr_write(NPS_CSR_POINT_COUNT, 31'(c));
   endtask

   initial begin
      logic [30:0] mag;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table under reset settings.
      query(3);
      query(0);
      // Fill the whole table, extremes first.
      load_point(8'd0, 0);
      load_point(8'd1, 1);
      load_point(8'd2, 2);
      load_point(8'd3, 2);
      for (int i = 4; i < NPS_MAX_POINTS; i++) load_point(8'(i), $urandom_range(2, 3));
      loaded_count = NPS_MAX_POINTS;
      // Tie: entries 4 and 5 at the same point; the earlier must win.
      send_beat(NPS_CMD_LOAD, 8'd4, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0);
      send_beat(NPS_CMD_LOAD, 8'd5, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0);
      csr_write(NPS_CSR_POINT_COUNT, 31'd6);
      send_beat(NPS_CMD_QUERY, 8'hff, 0, 0, 0, 32'h10000, 0, 0);
      send_beat(NPS_CMD_QUERY, 8'h00, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0);
      query(0);
      query(1);
      csr_write(NPS_CSR_MAX_MAG, 31'h7fff_ffff);
      query(0);
      query(1);
      query(2);
      csr_write(NPS_CSR_MAX_MAG, 31'd0);
      query(2);
      query(3);
      // Full table and a count beyond it.
      csr_write(NPS_CSR_POINT_COUNT, 31'd256);
      query(3);
      csr_write(NPS_CSR_POINT_COUNT, 31'd511);
      query(1);
      csr_write(NPS_CSR_POINT_COUNT, 31'd0);
      query(2);

      for (int phase = 0; phase < 16; phase++) begin
         case ($urandom_range(0, 3))
            0: mag = 31'd0;
            1: mag = 31'h7fff_ffff;
            2: mag = 31'($urandom_range(1, 1 << 20));
            default: mag = 31'($urandom);
         endcase
         csr_write(NPS_CSR_MAX_MAG, mag);
         set_count(phase % 4 == 0 ? 256 : 200);
         stall_free = (phase % 5 == 2);
         for (int k = 0; k < 36; k++) begin
            if ($urandom_range(0, 3) == 0)
               load_point(8'($urandom), $urandom_range(0, 3));
            else
               query($urandom_range(0, 3));
         end
         stall_free = 1'b0;
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0)
         $display("tb_nearest_point_steering_core OK");
      else
         $display("tb_nearest_point_steering_core NOT OK");
      $finish;
   end

endmodule
